// ===== hdl/rws_pkg.sv =====
// Package with the shared types, register codes and constants of the Ricker wavelet sample block.
package rws_pkg;

  localparam int IDX_W          = 16;
  localparam int CFG_W          = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int VAL_W          = 32;
  localparam int INDEX_BITS_DEF = 16;
  localparam int HORNER_TERMS   = 10;

  localparam logic [31:0] FREQUENCY_RST = 32'd655360;
  localparam logic [31:0] INTERVAL_RST  = 32'd4294967;
  localparam logic [31:0] START_RST     = 32'd0;
  localparam logic [31:0] DELAY_RST     = 32'd0;
  localparam logic [31:0] GAIN_RST      = 32'd65536;

  localparam logic [31:0] PI_Q29    = 32'd1686629713;
  localparam logic [31:0] LOG2E_Q31 = 32'd3098164009;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
  localparam logic [30:0] ONE_Q24   = 31'h0100_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREQUENCY       = 3'd0,
    REG_SAMPLE_INTERVAL = 3'd1,
    REG_START_TIME      = 3'd2,
    REG_DELAY           = 3'd3,
    REG_GAIN            = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] frequency;
    logic [31:0] interval;
    logic [40:0] tofs;
    logic [31:0] gain_mag;
    logic        gain_neg;
  } cfg_t;

  typedef struct packed {
    logic        far;
    logic [15:0] echo;
    logic        pneg;
    logic [30:0] pmag;
  } side_t;

  typedef struct packed {
    logic        far;
    logic [15:0] echo;
    logic [37:0] a;
  } arg_t;

  typedef struct packed {
    side_t       side;
    logic [6:0]  k;
    logic [31:0] r;
    logic [32:0] s;
  } hzn_t;

  typedef struct packed {
    side_t       side;
    logic [32:0] e;
  } exp_t;

endpackage

// ===== hdl/rws_cfg.sv =====
// Configuration register file with the derived time offset and gain magnitude.
module rws_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [rws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rws_pkg::CFG_W-1:0]        cfg_data,
  output rws_pkg::cfg_t                    cfg
);

  logic [31:0] freq_r, freq_nxt;
  logic [31:0] intv_r, intv_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] delay_r, delay_nxt;
  logic [31:0] gain_r, gain_nxt;
  logic [40:0] tofs_r;
  logic [31:0] gmag_r;
  logic        gneg_r;
  logic [32:0] diff;

  always_comb begin
    freq_nxt  = freq_r;
    intv_nxt  = intv_r;
    start_nxt = start_r;
    delay_nxt = delay_r;
    gain_nxt  = gain_r;
    if (cfg_valid && cfg_ready) begin
      case (rws_pkg::cfg_reg_t'(cfg_index))
        rws_pkg::REG_FREQUENCY:       freq_nxt  = cfg_data;
        rws_pkg::REG_SAMPLE_INTERVAL: intv_nxt  = cfg_data;
        rws_pkg::REG_START_TIME:      start_nxt = cfg_data;
        rws_pkg::REG_DELAY:           delay_nxt = cfg_data;
        rws_pkg::REG_GAIN:            gain_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  assign diff = {start_r[31], start_r} - {delay_r[31], delay_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r  <= rws_pkg::FREQUENCY_RST;
      intv_r  <= rws_pkg::INTERVAL_RST;
      start_r <= rws_pkg::START_RST;
      delay_r <= rws_pkg::DELAY_RST;
      gain_r  <= rws_pkg::GAIN_RST;
      tofs_r  <= '0;
      gmag_r  <= rws_pkg::GAIN_RST;
      gneg_r  <= 1'b0;
    end else begin
      freq_r  <= freq_nxt;
      intv_r  <= intv_nxt;
      start_r <= start_nxt;
      delay_r <= delay_nxt;
      gain_r  <= gain_nxt;
      tofs_r  <= {diff, 8'b0};
      gmag_r  <= gain_r[31] ? (~gain_r + 32'd1) : gain_r;
      gneg_r  <= gain_r[31];
    end
  end

  assign cfg.frequency = freq_r;
  assign cfg.interval  = intv_r;
  assign cfg.tofs      = tofs_r;
  assign cfg.gain_mag  = gmag_r;
  assign cfg.gain_neg  = gneg_r;

endmodule

// ===== hdl/rws_arg.sv =====
// Pipeline stages that form the time, the scaled product f*|t| and the argument a = (pi*f*t)^2.
module rws_arg #(
  parameter int INDEX_BITS = rws_pkg::INDEX_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [rws_pkg::IDX_W-1:0]    in_index,
  input  rws_pkg::cfg_t                cfg,
  output logic                         out_valid,
  output rws_pkg::arg_t                out_arg
);

  localparam logic [rws_pkg::IDX_W-1:0] IDX_MASK = (INDEX_BITS >= rws_pkg::IDX_W) ?
    {rws_pkg::IDX_W{1'b1}} : rws_pkg::IDX_W'((32'd1 << INDEX_BITS) - 32'd1);

  logic [rws_pkg::IDX_W-1:0] idx;
  logic        va_r, vb_r, vc_r, vd_r, ve_r, vf_r;
  logic [15:0] echo_a_r, echo_b_r, echo_c_r, echo_d_r, echo_e_r, echo_f_r;
  logic [47:0] p_r;
  logic [49:0] t, tneg;
  logic [48:0] tabs_nxt, tabs_r;
  logic [63:0] pl_r;
  logic [48:0] ph_r;
  logic [48:0] sum;
  logic        far_d_nxt, far_d_r, far_e_r, far_f_r;
  logic [33:0] ft_r;
  logic [62:0] xp_r;
  logic [63:0] sq_r;

  assign idx = in_index & IDX_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
    end
  end

  assign t        = {2'b00, p_r} + {{9{cfg.tofs[40]}}, cfg.tofs};
  assign tneg     = ~t + 50'd1;
  assign tabs_nxt = t[49] ? tneg[48:0] : t[48:0];

  assign sum       = 49'({ph_r[17:0], 16'b0}) + 49'(pl_r[63:16]);
  assign far_d_nxt = (ph_r[48:18] != '0) || (sum[48:34] != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r      <= 48'(idx) * 48'(cfg.interval);
      echo_a_r <= 16'(idx);
      tabs_r   <= tabs_nxt;
      echo_b_r <= echo_a_r;
      pl_r     <= 64'(cfg.frequency) * 64'(tabs_r[31:0]);
      ph_r     <= 49'(cfg.frequency) * 49'(tabs_r[48:32]);
      echo_c_r <= echo_b_r;
      ft_r     <= sum[33:0];
      far_d_r  <= far_d_nxt;
      echo_d_r <= echo_c_r;
      xp_r     <= 63'(ft_r[33:2]) * 63'(rws_pkg::PI_Q29);
      far_e_r  <= far_d_r;
      echo_e_r <= echo_d_r;
      sq_r     <= 64'(xp_r[62:31]) * 64'(xp_r[62:31]);
      far_f_r  <= far_e_r;
      echo_f_r <= echo_e_r;
    end
  end

  assign out_valid    = vf_r;
  assign out_arg.far  = far_f_r || (sq_r[63:62] != 2'b00);
  assign out_arg.echo = echo_f_r;
  assign out_arg.a    = sq_r[61:24];

endmodule

// ===== hdl/rws_hstep.sv =====
// One Horner step of the exp(-r) series, s = 1 - r*s/N, over three pipeline stages.
module rws_hstep #(
  parameter int N = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  rws_pkg::hzn_t in_h,
  output logic          out_valid,
  output rws_pkg::hzn_t out_h
);

  localparam logic [31:0] RECIP = 32'(64'hFFFF_FFFF / N);

  logic          v1_r, v2_r, v3_r;
  rws_pkg::hzn_t h1_r, h2_r, h3_r, h3_nxt;
  logic [63:0]   mp, ep;
  logic [31:0]   m1_r, m2_r, est2_r, q;
  logic [35:0]   prod, rem;

  assign mp = in_h.s[32] ? {in_h.r, 32'b0} : 64'(in_h.r) * 64'(in_h.s[31:0]);
  assign ep = 64'(m1_r) * 64'(RECIP);

  assign prod = 36'(est2_r) * 36'(N);
  assign rem  = 36'(m2_r) - prod;
  assign q    = (rem >= 36'(N)) ? (est2_r + 32'd1) : est2_r;

  always_comb begin
    h3_nxt   = h2_r;
    h3_nxt.s = rws_pkg::ONE_Q32 - {1'b0, q};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r   <= mp[63:32];
      h1_r   <= in_h;
      est2_r <= ep[63:32];
      m2_r   <= m1_r;
      h2_r   <= h1_r;
      h3_r   <= h3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_h     = h3_r;

endmodule

// ===== hdl/rws_exp.sv =====
// Range reduction of exp(-a) to 2^-k*exp(-r), the Horner pipeline and the final shift.
module rws_exp (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  rws_pkg::arg_t in_arg,
  output logic          out_valid,
  output rws_pkg::exp_t out_exp
);

  logic           vg_r, vh_r, vo_r;
  logic [63:0]    yp_r, rp_r;
  logic [6:0]     k_r;
  logic [30:0]    twoa;
  rws_pkg::side_t side_g_nxt, side_g_r, side_h_r, side_o_r;
  logic [32:0]    e_nxt, e_r;
  rws_pkg::hzn_t  hz [0:rws_pkg::HORNER_TERMS];
  logic           hv [0:rws_pkg::HORNER_TERMS];

  assign twoa = in_arg.a[37:7];

  always_comb begin
    side_g_nxt.far  = in_arg.far;
    side_g_nxt.echo = in_arg.echo;
    side_g_nxt.pneg = twoa > rws_pkg::ONE_Q24;
    side_g_nxt.pmag = side_g_nxt.pneg ? (twoa - rws_pkg::ONE_Q24)
                                      : (rws_pkg::ONE_Q24 - twoa);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
      vh_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      vg_r <= in_valid;
      vh_r <= vg_r;
      vo_r <= hv[rws_pkg::HORNER_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yp_r     <= 64'(in_arg.a[37:6]) * 64'(rws_pkg::LOG2E_Q31);
      side_g_r <= side_g_nxt;
      rp_r     <= 64'(yp_r[56:25]) * 64'(rws_pkg::LN2_Q32);
      k_r      <= yp_r[63:57];
      side_h_r <= side_g_r;
      e_r      <= e_nxt;
      side_o_r <= hz[rws_pkg::HORNER_TERMS].side;
    end
  end

  assign hv[0]      = vh_r;
  assign hz[0].side = side_h_r;
  assign hz[0].k    = k_r;
  assign hz[0].r    = rp_r[63:32];
  assign hz[0].s    = rws_pkg::ONE_Q32;

  for (genvar gi = 0; gi < rws_pkg::HORNER_TERMS; gi++) begin : g_step
    rws_hstep #(
      .N(rws_pkg::HORNER_TERMS - gi)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (hv[gi]),
      .in_h     (hz[gi]),
      .out_valid(hv[gi+1]),
      .out_h    (hz[gi+1])
    );
  end

  assign e_nxt = hz[rws_pkg::HORNER_TERMS].k[6] ? '0 :
                 (hz[rws_pkg::HORNER_TERMS].s >> hz[rws_pkg::HORNER_TERMS].k[5:0]);

  assign out_valid    = vo_r;
  assign out_exp.side = side_o_r;
  assign out_exp.e    = e_r;

endmodule

// ===== hdl/rws_out.sv =====
// Wavelet product, gain scaling, rounding and saturation to signed Q16.16.
module rws_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  rws_pkg::exp_t               in_exp,
  input  rws_pkg::cfg_t               cfg,
  output logic                        out_valid,
  output logic [rws_pkg::VAL_W-1:0]   out_value,
  output logic [15:0]                 out_echo
);

  logic           v1_r, v2_r, v3_r, v4_r;
  rws_pkg::side_t side1_r, side2_r, side3_r;
  logic [63:0]    wp_r, gp_r, rs;
  logic [39:0]    wv;
  logic [32:0]    w_r;
  logic [31:0]    m, mc, res;
  logic           neg;
  logic [31:0]    val_r;
  logic [15:0]    echo_r;

  assign wv = wp_r[63:24];

  always_comb begin
    rs  = gp_r + 64'h0000_0000_8000_0000;
    m   = rs[63:32];
    neg = (side3_r.pneg != cfg.gain_neg) && (m != 32'd0);
    mc  = 32'd0;
    if (side3_r.far) begin
      res = 32'd0;
    end else if (neg) begin
      mc  = (m > 32'h8000_0000) ? 32'h8000_0000 : m;
      res = ~mc + 32'd1;
    end else begin
      res = (m > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wp_r    <= in_exp.e[32] ? {1'b0, in_exp.side.pmag, 32'b0}
                              : 64'(in_exp.side.pmag) * 64'(in_exp.e[31:0]);
      side1_r <= in_exp.side;
      w_r     <= (wv > 40'(rws_pkg::ONE_Q32)) ? rws_pkg::ONE_Q32 : wv[32:0];
      side2_r <= side1_r;
      gp_r    <= w_r[32] ? {cfg.gain_mag, 32'b0}
                         : 64'(cfg.gain_mag) * 64'(w_r[31:0]);
      side3_r <= side2_r;
      val_r   <= res;
      echo_r  <= side3_r.echo;
    end
  end

  assign out_valid = v4_r;
  assign out_value = val_r;
  assign out_echo  = echo_r;

endmodule

// ===== hdl/ricker_wavelet_sample.sv =====
// Ricker wavelet sample generator: 43-stage pipeline, one sample index per clock while the output is not stalled.
// A new index enters before earlier ones have left: one transaction per cycle unless the output stalls.
// The pipeline holds the ten Horner steps of exp(-r), three stages each, plus 13 other stages.
// A stalled output freezes every stage together, so nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits and loads the register reset values.
module ricker_wavelet_sample #(
  parameter int INDEX_BITS = rws_pkg::INDEX_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [15:0]                      in_tdata,   // [15:0] sample_index
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [47:0]                      out_tdata,  // [31:0] sample_value, [47:32] index_echo
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rws_pkg::CFG_W-1:0]        cfg_data
);

  rws_pkg::cfg_t cfg;
  rws_pkg::arg_t arg;
  rws_pkg::exp_t expv;
  logic          en;
  logic          arg_valid, exp_valid;
  logic [31:0]   value;
  logic [15:0]   echo;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  rws_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  rws_arg #(
    .INDEX_BITS(INDEX_BITS)
  ) u_arg (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_index (in_tdata),
    .cfg      (cfg),
    .out_valid(arg_valid),
    .out_arg  (arg)
  );

  rws_exp u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (arg_valid),
    .in_arg   (arg),
    .out_valid(exp_valid),
    .out_exp  (expv)
  );

  rws_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (exp_valid),
    .in_exp   (expv),
    .cfg      (cfg),
    .out_valid(out_tvalid),
    .out_value(value),
    .out_echo (echo)
  );

  assign out_tdata = {echo, value};

endmodule
